/* src/b2b_pkg.sv */
// Package for the BLAKE2b hash engine: block constants, IV words,
// message schedule and G index helpers. No dependencies.
package b2b_pkg;

    localparam int BLOCK_BYTES      = 128;
    localparam int MAX_DIGEST_BYTES = 64;
    localparam int ROUND_COUNT      = 12;
    localparam int WORD_W           = 64;
    localparam int BLOCK_WORDS      = BLOCK_BYTES / 8;
    localparam int VEC_WORDS        = 16;

    // Configuration register indexes
    localparam logic CFG_DIGEST_LEN = 1'b0;
    localparam logic CFG_KEY_LEN    = 1'b1;

    // Schedule rows, entry i in nibble i
    localparam logic [63:0] SIGMA [10] = '{
        64'hFEDCBA9876543210, 64'h357B20C16DF984AE, 64'h491763EADF250C8B,
        64'h8F04A562EBCD1397, 64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
        64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD, 64'h5A417D2C803B9EF6,
        64'h0DC3E9BF5167482A
    };

    function automatic logic [63:0] b2b_iv(input logic [2:0] idx);
        logic [63:0] w;
        case (idx)
            3'd0:    w = 64'h6a09e667f3bcc908;
            3'd1:    w = 64'hbb67ae8584caa73b;
            3'd2:    w = 64'h3c6ef372fe94f82b;
            3'd3:    w = 64'ha54ff53a5f1d36f1;
            3'd4:    w = 64'h510e527fade682d1;
            3'd5:    w = 64'h9b05688c2b3e6c1f;
            3'd6:    w = 64'h1f83d9abfb41bd6b;
            default: w = 64'h5be0cd19137e2179;
        endcase
        return w;
    endfunction

    // Message word index for a round (0..11) and schedule slot
    function automatic logic [3:0] b2b_sigma(input logic [3:0] rnd, input logic [3:0] slot);
        logic [63:0] row;
        logic [3:0]  r10;
        r10 = (rnd >= 4'd10) ? (rnd - 4'd10) : rnd;
        row = SIGMA[r10];
        return row[{slot, 2'b00} +: 4];
    endfunction

    // Work vector index of operand sel (a, b, c, d) for mixing gi
    function automatic logic [3:0] b2b_gidx(input logic [2:0] gi, input logic [1:0] sel);
        logic [1:0] j;
        j = gi[1:0];
        if (gi[2]) begin
            j = j + sel;
        end
        return {sel, j};
    endfunction

    function automatic logic [63:0] b2b_rotr(input logic [63:0] w, input int c);
        return (w >> c) | (w << (64 - c));
    endfunction

endpackage

/* src/b2b_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module b2b_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/blake2b_hash_engine.sv */
// BLAKE2b hash engine top level: byte packer, compression sequencer
// and digest output. Uses b2b_pkg and b2b_ram (work vector, block buffer).
//
//  channel  | dir | tdata (low bit up)                     | tuser  | tlast
//  s_axis   | in  | data_word[63:0], byte_count[67:64]     | is_key | last_of_message
//  m_axis   | out | digest_word[63:0], word_index[66:64],  | -      | last_word
//           |     | valid_bytes[70:67]                     |        |
//  cfg      | in  | we, index (0 digest bytes, 1 key bytes), data[6:0]
//
// Each word goes through an accept step, a prepare step and one packing step per
// byte it carries. A compression loads 16 work vector words, runs 96 mixings
// (read, four G quarter steps, write back) on one shared G unit with a single
// work vector read port, then updates the chain. Digest words leave one at a time.
// Reset is synchronous; no clearing pass, the buffer uses a fill count.
// Input is held off from the first byte of a word until its work is done.
module blake2b_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // data_word[63:0], byte_count[67:64]
    input  logic        i_s_axis_tuser,   // is_key
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // digest_word, word_index, valid_bytes
    output logic        o_m_axis_tlast
);
    import b2b_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_BYTES, S_FINP, S_INIT, S_RD,
        S_G1, S_G2, S_G3, S_G4, S_WR, S_FIN, S_OLOAD, S_OUT
    } t_state;

    t_state        r_state;
    logic [6:0]    r_dlen, r_klen, r_dlen_eff, r_klen_eff, r_key_taken;
    logic          r_msg_active, r_key_phase, r_final;
    logic [63:0]   r_h [8];
    logic [127:0]  r_t;
    logic [7:0]    r_fill;
    logic [4:0]    r_wcnt;
    logic [63:0]   r_acc, r_word;
    logic [3:0]    r_nin, r_nbytes, r_bi, r_mk;
    logic          r_is_key, r_last;
    logic [4:0]    r_cnt;
    logic [3:0]    r_round;
    logic [2:0]    r_gi;
    logic [63:0]   r_va, r_vb, r_vc, r_vd, r_mx, r_my;
    logic          r_ovalid, r_olast;
    logic [63:0]   r_odata;
    logic [2:0]    r_oidx;
    logic [3:0]    r_ovb;

    // RAM ports
    logic          v_we, b_we;
    logic [3:0]    v_waddr, v_raddr, b_waddr, b_raddr;
    logic [63:0]   v_wdata, b_wdata, v_rdata, b_rdata;

    b2b_ram #(.WIDTH(WORD_W), .DEPTH(VEC_WORDS)) u_vec (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    b2b_ram #(.WIDTH(WORD_W), .DEPTH(BLOCK_WORDS)) u_buf (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    // Input field unpack and start-of-message lengths
    logic [3:0]  in_n;
    logic [6:0]  deff, keff;
    assign in_n = (i_s_axis_tdata[67:64] > 4'd8) ? 4'd8 : i_s_axis_tdata[67:64];
    assign deff = (r_dlen == 7'd0) ? 7'd1 :
                  (r_dlen > 7'(MAX_DIGEST_BYTES)) ? 7'(MAX_DIGEST_BYTES) : r_dlen;
    assign keff = (r_klen > 7'(MAX_DIGEST_BYTES)) ? 7'(MAX_DIGEST_BYTES) : r_klen;

    // Byte packing
    logic [7:0]  cur_byte;
    logic [63:0] acc_new;
    logic [6:0]  key_rem;
    assign cur_byte = 8'(r_word >> {r_bi[2:0], 3'b000});
    assign acc_new  = r_acc | ({56'd0, cur_byte} << {r_fill[2:0], 3'b000});
    assign key_rem  = r_klen_eff - r_key_taken;

    // Message word select: stored, partial, or zero past the fill
    logic [63:0] m_sel;
    always_comb begin
        if ({1'b0, r_mk} < r_wcnt) begin
            m_sel = b_rdata;
        end else if ({1'b0, r_mk} == r_wcnt) begin
            m_sel = r_acc;
        end else begin
            m_sel = '0;
        end
    end

    // G unit quarter steps
    logic [63:0] s1_a, s1_d, s2_c, s2_b, s3_a, s3_d, s4_c, s4_b;
    assign s1_a = r_va + r_vb + r_mx;
    assign s1_d = b2b_rotr(r_vd ^ s1_a, 32);
    assign s2_c = r_vc + r_vd;
    assign s2_b = b2b_rotr(r_vb ^ s2_c, 24);
    assign s3_a = r_va + r_vb + r_my;
    assign s3_d = b2b_rotr(r_vd ^ s3_a, 16);
    assign s4_c = r_vc + r_vd;
    assign s4_b = b2b_rotr(r_vb ^ s4_c, 63);

    // Work vector load value
    logic [63:0] init_word;
    always_comb begin
        init_word = b2b_iv(r_cnt[2:0]);
        if (r_cnt[3:0] == 4'd12) begin
            init_word = init_word ^ r_t[63:0];
        end else if (r_cnt[3:0] == 4'd13) begin
            init_word = init_word ^ r_t[127:64];
        end else if (r_cnt[3:0] == 4'd14 && r_final) begin
            init_word = ~init_word;
        end
        if (!r_cnt[3]) begin
            init_word = r_h[r_cnt[2:0]];
        end
    end

    // RAM control
    always_comb begin
        v_we    = 1'b0;
        v_waddr = r_cnt[3:0];
        v_wdata = init_word;
        v_raddr = r_cnt[3:0];
        b_we    = 1'b0;
        b_waddr = r_fill[6:3];
        b_wdata = acc_new;
        b_raddr = b2b_sigma(r_round, {r_gi, r_cnt[0]});
        unique case (r_state)
            S_INIT: begin
                v_we = 1'b1;
            end
            S_RD: begin
                v_raddr = b2b_gidx(r_gi, r_cnt[1:0]);
            end
            S_WR: begin
                v_we    = 1'b1;
                v_waddr = b2b_gidx(r_gi, r_cnt[1:0]);
                case (r_cnt[1:0])
                    2'd0:    v_wdata = r_va;
                    2'd1:    v_wdata = r_vb;
                    2'd2:    v_wdata = r_vc;
                    default: v_wdata = r_vd;
                endcase
            end
            S_BYTES: begin
                b_we = (r_bi != r_nbytes) && !r_fill[7] && (r_fill[2:0] == 3'd7);
            end
            default: begin
            end
        endcase
    end

    // Digest word trim
    logic [6:0]  out_rem;
    logic [3:0]  out_vb;
    logic [63:0] out_mask;
    assign out_rem  = r_dlen_eff - {1'b0, r_cnt[2:0], 3'b000};
    assign out_vb   = (out_rem > 7'd8) ? 4'd8 : out_rem[3:0];
    assign out_mask = out_vb[3] ? '1 : ~({64{1'b1}} << {out_vb[2:0], 3'b000});

    // Main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dlen       <= 7'(MAX_DIGEST_BYTES);
            r_klen       <= '0;
            r_msg_active <= 1'b0;
            r_key_phase  <= 1'b0;
            r_ovalid     <= 1'b0;
            r_cnt        <= '0;
            r_round      <= '0;
            r_gi         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DIGEST_LEN: r_dlen <= i_cfg_wdata;
                    CFG_KEY_LEN:    r_klen <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_mk <= b_raddr;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_word   <= i_s_axis_tdata[63:0];
                        r_nin    <= in_n;
                        r_is_key <= i_s_axis_tuser;
                        r_last   <= i_s_axis_tlast;
                        if (!r_msg_active) begin
                            r_msg_active <= 1'b1;
                            r_dlen_eff   <= deff;
                            r_klen_eff   <= keff;
                            r_h[0] <= b2b_iv(3'd0) ^
                                      {32'd0, 8'h01, 8'h01, 1'b0, keff, 1'b0, deff};
                            for (int i = 1; i < 8; i++) begin
                                r_h[i] <= b2b_iv(3'(i));
                            end
                            r_t         <= '0;
                            r_fill      <= '0;
                            r_wcnt      <= '0;
                            r_acc       <= '0;
                            r_key_phase <= (keff != 7'd0);
                            r_key_taken <= '0;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_bi <= '0;
                    if (r_is_key) begin
                        if (!r_key_phase) begin
                            r_nbytes <= '0;
                        end else if (key_rem < {3'd0, r_nin}) begin
                            r_nbytes <= key_rem[3:0];
                        end else begin
                            r_nbytes <= r_nin;
                        end
                    end else begin
                        r_nbytes <= r_nin;
                        if (r_key_phase) begin
                            r_key_phase <= 1'b0;
                            r_fill      <= 8'(BLOCK_BYTES);
                        end
                    end
                    r_state <= S_BYTES;
                end
                S_BYTES: begin
                    if (r_bi == r_nbytes) begin
                        r_state <= r_last ? S_FINP : S_IDLE;
                    end else if (r_fill[7]) begin
                        // full block with more data behind it
                        r_t     <= r_t + 128'(BLOCK_BYTES);
                        r_final <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_INIT;
                    end else begin
                        r_fill <= r_fill + 8'd1;
                        r_bi   <= r_bi + 4'd1;
                        if (r_is_key) begin
                            r_key_taken <= r_key_taken + 7'd1;
                        end
                        if (r_fill[2:0] == 3'd7) begin
                            r_wcnt <= {1'b0, r_fill[6:3]} + 5'd1;
                            r_acc  <= '0;
                        end else begin
                            r_acc <= acc_new;
                        end
                    end
                end
                S_FINP: begin
                    r_key_phase <= 1'b0;
                    r_final     <= 1'b1;
                    r_cnt       <= '0;
                    if (r_key_phase) begin
                        r_fill <= 8'(BLOCK_BYTES);
                        r_t    <= r_t + 128'(BLOCK_BYTES);
                    end else begin
                        r_t <= r_t + {120'd0, r_fill};
                    end
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    if (r_cnt == 5'd15) begin
                        r_cnt   <= '0;
                        r_round <= '0;
                        r_gi    <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_RD: begin
                    // read data is registered and arrives in the cycle after its address
                    case (r_cnt[2:0])
                        3'd1: begin
                            r_va <= v_rdata;
                            r_mx <= m_sel;
                        end
                        3'd2: begin
                            r_vb <= v_rdata;
                            r_my <= m_sel;
                        end
                        3'd3:    r_vc <= v_rdata;
                        3'd4:    r_vd <= v_rdata;
                        default: ;
                    endcase
                    if (r_cnt == 5'd4) begin
                        r_state <= S_G1;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_G1: begin
                    r_va    <= s1_a;
                    r_vd    <= s1_d;
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_vc    <= s2_c;
                    r_vb    <= s2_b;
                    r_state <= S_G3;
                end
                S_G3: begin
                    r_va    <= s3_a;
                    r_vd    <= s3_d;
                    r_state <= S_G4;
                end
                S_G4: begin
                    r_vc    <= s4_c;
                    r_vb    <= s4_b;
                    r_cnt   <= '0;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_cnt == 5'd3) begin
                        r_cnt <= '0;
                        r_gi  <= r_gi + 3'd1;
                        if (r_gi == 3'd7 && r_round == 4'(ROUND_COUNT - 1)) begin
                            r_round <= '0;
                            r_state <= S_FIN;
                        end else begin
                            if (r_gi == 3'd7) begin
                                r_round <= r_round + 4'd1;
                            end
                            r_state <= S_RD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_FIN: begin
                    // h[i] takes v[i] then v[i+8]
                    if (r_cnt != 5'd0) begin
                        r_h[3'(r_cnt - 5'd1)] <= r_h[3'(r_cnt - 5'd1)] ^ v_rdata;
                    end
                    if (r_cnt == 5'd16) begin
                        r_cnt <= '0;
                        if (r_final) begin
                            r_state <= S_OLOAD;
                        end else begin
                            r_fill  <= '0;
                            r_wcnt  <= '0;
                            r_acc   <= '0;
                            r_state <= S_BYTES;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_OLOAD: begin
                    r_odata  <= r_h[r_cnt[2:0]] & out_mask;
                    r_oidx   <= r_cnt[2:0];
                    r_ovb    <= out_vb;
                    r_olast  <= (out_rem <= 7'd8);
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_msg_active <= 1'b0;
                            r_state      <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + 5'd1;
                            r_state <= S_OLOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_ovb, r_oidx, r_odata};
    assign o_m_axis_tlast  = r_olast;
endmodule

/* tb/blake2b_hash_engine_tb.sv */
// Self-checking testbench for blake2b_hash_engine: stream driver, digest monitor
// and a BLAKE2b predictor in plain SystemVerilog. Depends on b2b_pkg and the RTL.
module blake2b_hash_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import b2b_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1500;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        key;
        logic        last;
    } t_msg_word;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic [3:0]  vbytes;
        logic        lastw;
    } t_digest_word;

    localparam logic [63:0] IV_W [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };
    localparam int SCHED [10][16] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
        '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
        '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
        '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
        '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
        '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
        '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
        '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
        '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata = '0;  // data_word[63:0], byte_count[67:64]
    logic        i_s_axis_tuser = 1'b0; // is_key
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;       // digest_word[63:0], word_index[66:64], valid_bytes[70:67]
    logic        o_m_axis_tlast;

    blake2b_hash_engine dut (.*);

    always #6 i_clk = ~i_clk;

    // Stimulus and expectations
    t_msg_word    word_q[$];
    t_digest_word digest_q[$];
    t_msg_word    cur_word;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           errors = 0;
    int           messages_done = 0;
    int           digests_checked = 0;
    int           quiet_cycles = 0;
    int           words_added = 0;

    // Predictor state
    logic [6:0]   reg_dlen = 7'd64;
    logic [6:0]   reg_klen = 7'd0;
    logic [63:0]  chain [8];
    logic [63:0]  blk [16];
    logic [63:0]  wv [16];
    logic [127:0] bcount;
    int           fill;
    bit           msg_on = 0;
    bit           key_on;
    int           key_got;
    int           dlen_act;
    int           klen_act;

    function automatic logic [63:0] rot_r(logic [63:0] w, int c);
        return (w >> c) | (w << (64 - c));
    endfunction

    task automatic gmix(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
        wv[a] = wv[a] + wv[b] + x;
        wv[d] = rot_r(wv[d] ^ wv[a], 32);
        wv[c] = wv[c] + wv[d];
        wv[b] = rot_r(wv[b] ^ wv[c], 24);
        wv[a] = wv[a] + wv[b] + y;
        wv[d] = rot_r(wv[d] ^ wv[a], 16);
        wv[c] = wv[c] + wv[d];
        wv[b] = rot_r(wv[b] ^ wv[c], 63);
    endtask

    task automatic compress_block(bit fin);
        int j;
        for (int i = 0; i < 8; i++) begin
            wv[i]     = chain[i];
            wv[i + 8] = IV_W[i];
        end
        wv[12] ^= bcount[63:0];
        wv[13] ^= bcount[127:64];
        if (fin) begin
            wv[14] = ~wv[14];
        end
        for (int r = 0; r < ROUND_COUNT; r++) begin
            j = r % 10;
            gmix(0, 4, 8, 12, blk[SCHED[j][0]], blk[SCHED[j][1]]);
            gmix(1, 5, 9, 13, blk[SCHED[j][2]], blk[SCHED[j][3]]);
            gmix(2, 6, 10, 14, blk[SCHED[j][4]], blk[SCHED[j][5]]);
            gmix(3, 7, 11, 15, blk[SCHED[j][6]], blk[SCHED[j][7]]);
            gmix(0, 5, 10, 15, blk[SCHED[j][8]], blk[SCHED[j][9]]);
            gmix(1, 6, 11, 12, blk[SCHED[j][10]], blk[SCHED[j][11]]);
            gmix(2, 7, 8, 13, blk[SCHED[j][12]], blk[SCHED[j][13]]);
            gmix(3, 4, 9, 14, blk[SCHED[j][14]], blk[SCHED[j][15]]);
        end
        for (int i = 0; i < 8; i++) begin
            chain[i] ^= wv[i] ^ wv[i + 8];
        end
    endtask

    task automatic start_hash();
        dlen_act = (reg_dlen == 0) ? 1 : (reg_dlen > MAX_DIGEST_BYTES) ? MAX_DIGEST_BYTES
                                                                          : int'(reg_dlen);
        klen_act = (reg_klen > MAX_DIGEST_BYTES) ? MAX_DIGEST_BYTES : int'(reg_klen);
        for (int i = 0; i < 8; i++) begin
            chain[i] = IV_W[i];
        end
        chain[0] ^= 64'(dlen_act) | (64'(klen_act) << 8) | (64'd1 << 16) | (64'd1 << 24);
        bcount = '0;
        for (int i = 0; i < 16; i++) begin
            blk[i] = '0;
        end
        fill    = 0;
        key_on  = (klen_act != 0);
        key_got = 0;
    endtask

    // A full block goes through compression only once a further byte shows up
    task automatic absorb_byte(logic [7:0] b);
        if (fill >= BLOCK_BYTES) begin
            bcount += BLOCK_BYTES;
            compress_block(0);
            for (int i = 0; i < 16; i++) begin
                blk[i] = '0;
            end
            fill = 0;
        end
        blk[fill / 8][8 * (fill % 8) +: 8] = b;
        fill++;
    endtask

    task automatic hash_word(t_msg_word w);
        int n;
        int nwords;
        int vb;
        t_digest_word d;
        n = (w.nbytes > 8) ? 8 : int'(w.nbytes);
        if (!msg_on) begin
            start_hash();
            msg_on = 1;
        end
        if (w.key) begin
            if (key_on) begin
                for (int i = 0; i < n && key_got < klen_act; i++) begin
                    absorb_byte(w.data[8 * i +: 8]);
                    key_got++;
                end
            end
        end else begin
            // first message word closes the key block
            if (key_on) begin
                key_on = 0;
                fill   = BLOCK_BYTES;
            end
            for (int i = 0; i < n; i++) begin
                absorb_byte(w.data[8 * i +: 8]);
            end
        end
        if (w.last) begin
            if (key_on) begin
                key_on = 0;
                fill   = BLOCK_BYTES;
            end
            bcount += fill;
            compress_block(1);
            nwords = (dlen_act + 7) / 8;
            for (int k = 0; k < nwords; k++) begin
                vb = dlen_act - 8 * k;
                if (vb > 8) begin
                    vb = 8;
                end
                d.word = chain[k];
                if (vb < 8) begin
                    d.word &= (64'd1 << (8 * vb)) - 64'd1;
                end
                d.idx    = 3'(k);
                d.vbytes = 4'(vb);
                d.lastw  = (k + 1 == nwords);
                digest_q.push_back(d);
            end
            msg_on = 0;
            messages_done++;
        end
    endtask

    // Input driver: predicts on every accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                hash_word(cur_word);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = word_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {4'd0, cur_word.nbytes, cur_word.data};
                    i_s_axis_tuser  <= cur_word.key;
                    i_s_axis_tlast  <= cur_word.last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink ready with random stalls
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Digest monitor
    always @(posedge i_clk) begin
        t_digest_word e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                e = digest_q.pop_front();
                digests_checked++;
                if (o_m_axis_tdata[63:0] !== e.word) begin
                    $display("%0t: digest_word exp %h got %h", $time, e.word,
                             o_m_axis_tdata[63:0]);
                    errors++;
                end
                if (o_m_axis_tdata[66:64] !== e.idx) begin
                    $display("%0t: word_index exp %0d got %0d", $time, e.idx,
                             o_m_axis_tdata[66:64]);
                    errors++;
                end
                if (o_m_axis_tdata[70:67] !== e.vbytes) begin
                    $display("%0t: valid_bytes exp %0d got %0d", $time, e.vbytes,
                             o_m_axis_tdata[70:67]);
                    errors++;
                end
                if (o_m_axis_tlast !== e.lastw) begin
                    $display("%0t: last_word exp %0d got %0d", $time, e.lastw,
                             o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (word_q.size() > 0 || i_s_axis_tvalid || digest_q.size() > 0) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("blake2b_hash_engine_tb: errors");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic idx, logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_DIGEST_LEN) begin
            reg_dlen = val;
        end else begin
            reg_klen = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Let every queued word go in and every digest word come out
    task automatic drain();
        while (word_q.size() > 0 || i_s_axis_tvalid || digest_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_word(logic [63:0] d, logic [3:0] n, logic k, logic l);
        t_msg_word w;
        w.data = d; w.nbytes = n; w.key = k; w.last = l;
        word_q.push_back(w);
        words_added++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // One message: a well-formed key and body, or a noisy mix of flags and counts
    task automatic add_message(int klen, int nbody, bit noisy);
        int nk;
        if (noisy) begin
            for (int i = 0; i < nbody; i++) begin
                add_word(rand64(), 4'($urandom_range(15)), 1'($urandom_range(1)),
                         (i == nbody - 1));
            end
        end else begin
            nk = (klen + 7) / 8 + (($urandom_range(7) == 0) ? 1 : 0);
            for (int i = 0; i < nk; i++) begin
                add_word(rand64(), (i == nk - 1 && klen % 8 != 0) ? 4'(klen % 8) : 4'd8,
                         1'b1, 1'b0);
            end
            if (nbody == 0) begin
                add_word(rand64(), 4'd0, 1'b0, 1'b1);
            end
            for (int i = 0; i < nbody; i++) begin
                add_word(rand64(), (i == nbody - 1) ? 4'($urandom_range(1, 8)) : 4'd8,
                         1'b0, (i == nbody - 1));
            end
        end
    endtask

    function automatic logic [6:0] pick_len();
        case ($urandom_range(5))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    initial begin
        int phase_start;
        int nbody;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset lengths, empty message and a short string
        add_word(64'h0, 4'd0, 1'b0, 1'b1);
        add_word(64'h636261, 4'd3, 1'b0, 1'b1);
        // a block of exactly 128 bytes stays held until the last word
        for (int i = 0; i < 16; i++) begin
            add_word(64'hffffffffffffffff, 4'd8, 1'b0, (i == 15));
        end
        drain();

        // Longest key, shortest digest; then out-of-range lengths
        cfg_write(CFG_DIGEST_LEN, 7'd1);
        cfg_write(CFG_KEY_LEN, 7'd64);
        add_message(64, 2, 0);
        add_word(64'h0123456789abcdef, 4'd15, 1'b1, 1'b1);  // key only, count clipped
        drain();
        cfg_write(CFG_DIGEST_LEN, 7'd0);
        cfg_write(CFG_KEY_LEN, 7'd127);
        add_word(64'haa, 4'd8, 1'b1, 1'b0);                 // short key
        add_word(64'h55, 4'd0, 1'b0, 1'b0);                 // zero count, not last
        add_word(64'h77, 4'd8, 1'b1, 1'b1);                 // key after body: ignored
        drain();
        cfg_write(CFG_DIGEST_LEN, 7'd127);
        cfg_write(CFG_KEY_LEN, 7'd0);
        add_word(64'h1234, 4'd8, 1'b1, 1'b0);               // key word while unkeyed
        add_word(64'hffffffffffffffff, 4'd8, 1'b0, 1'b1);
        drain();

        // Random phases with three idling profiles
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 48 : 0;
            recv_idle_pct = (ph < 3) ? 48 : (ph < 6) ? 8 : 0;
            cfg_write(CFG_DIGEST_LEN, pick_len());
            cfg_write(CFG_KEY_LEN, pick_len());
            phase_start = words_added;
            while (words_added - phase_start < 10) begin
                nbody = ($urandom_range(9) == 0) ? $urandom_range(16, 20) : $urandom_range(4);
                add_message(int'(reg_klen > 64 ? 64 : reg_klen), nbody + 1,
                            $urandom_range(4) == 0);
            end
            drain();
        end

        $display("covered %0d messages and %0d digest words over 9 random phases",
                 messages_done, digests_checked);
        if (errors == 0) begin
            $display("blake2b_hash_engine_tb: clean");
        end else begin
            $display("blake2b_hash_engine_tb: errors");
        end
        $finish;
    end
endmodule

/* filelist.f */
src/b2b_pkg.sv
src/b2b_ram.sv
src/blake2b_hash_engine.sv
tb/blake2b_hash_engine_tb.sv
